// File: rtl/oaids_pkg.sv
// Shared types and codes for the ordered array insert/delete/search block.
`timescale 1ns / 1ps
package oaids_pkg;

	localparam int SLOT_W  = 7;
	localparam int VALUE_W = 32;
	localparam int INDEX_W = 6;

	typedef logic [1:0] func_t;
	typedef logic [2:0] status_t;

	localparam func_t FUNC_INSERT   = 2'd0;
	localparam func_t FUNC_DELETE   = 2'd1;
	localparam func_t FUNC_TRAVERSE = 2'd2;
	localparam func_t FUNC_SEARCH   = 2'd3;

	localparam status_t STAT_INSERTED = 3'd0;
	localparam status_t STAT_DELETED  = 3'd1;
	localparam status_t STAT_LISTED   = 3'd2;
	localparam status_t STAT_EMPTY    = 3'd3;
	localparam status_t STAT_FOUND    = 3'd4;
	localparam status_t STAT_NOTFOUND = 3'd5;
	localparam status_t STAT_REJECTED = 3'd6;

	typedef struct packed {
		func_t                     func;
		logic signed [VALUE_W-1:0] item_value;
		logic [SLOT_W-1:0]         slot;
	} req_t;

	typedef struct packed {
		status_t                   status;
		logic signed [VALUE_W-1:0] out_value;
		logic [INDEX_W-1:0]        out_index;
		logic                      last;
	} res_t;

endpackage

// File: rtl/oaids_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module oaids_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/ordered_array_insert_delete_search.sv
// Top level: positional list with insert, delete, traverse and search.
//
//  channel | ports            | transfer when
//  --------+------------------+----------------------------------------
//  request | start, busy, req | rising edge with start high, busy low
//  result  | valid, res       | rising edge ending the cycle valid is high
//
// All entries sit in one RAM with one read and one write port; a shared
// read/write step moves, lists or compares one entry at a time: ST_STEP
// issues the read and ST_USE writes, lists or compares the data. Insert
// shifts the entries from slot p upward, delete moves those above p down;
// traverse visits every entry; search stops at the first match.
// Rejected requests and traverse of an empty list are answered from idle.
// Each result shows up in the cycle after the step that makes it.
// Reset clears count and control only; RAM contents stay undefined, and
// only entries below count are ever read. The receiver cannot stall: each
// result is held on valid/res for exactly one cycle.
`timescale 1ns / 1ps
module ordered_array_insert_delete_search #(
	parameter int DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  oaids_pkg::req_t  req,
	output logic             valid,
	output oaids_pkg::res_t  res
);
	import oaids_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_STEP = 2'd1; // check bound, issue read or finish
	localparam logic [1:0] ST_USE  = 2'd2; // consume read data

	logic [1:0]                state_q, state_d;
	func_t                     op_q, op_d;
	logic signed [VALUE_W-1:0] val_q, val_d;
	logic [CW-1:0]             slot_q, slot_d;
	logic [CW-1:0]             idx_q, idx_d;
	logic [CW-1:0]             count_q, count_d;
	logic                      valid_q, valid_d;
	res_t                      res_q, res_d;

	// RAM port
	logic                      ram_we, ram_re;
	logic [CW-1:0]             ram_widx, ram_ridx;
	logic [VALUE_W-1:0]        ram_wdata, ram_rdata;

	// shared index unit
	logic [CW-1:0]             idx_inc, idx_dec, cmp_a, cmp_b;
	logic                      cmp_lt;

	assign idx_inc = idx_q + CW'(1);
	assign idx_dec = idx_q - CW'(1);

	// one comparator serves every operation's loop bound
	always_comb begin
		unique case (op_q)
			FUNC_INSERT: begin
				cmp_a = slot_q;
				cmp_b = idx_q;
			end
			FUNC_SEARCH: begin
				cmp_a = idx_q;
				cmp_b = count_q;
			end
			default: begin
				cmp_a = idx_inc;
				cmp_b = count_q;
			end
		endcase
	end
	assign cmp_lt = cmp_a < cmp_b;

	oaids_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_widx[AW-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_ridx[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		val_d     = val_q;
		slot_d    = slot_q;
		idx_d     = idx_q;
		count_d   = count_q;
		valid_d   = 1'b0;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_widx  = idx_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_ridx  = idx_q;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_d      = req.func;
					val_d     = req.item_value;
					res_d     = '0;
					res_d.last = 1'b1;
					unique case (req.func)
						FUNC_INSERT: begin
							if (count_q >= CW'(DEPTH) || req.slot > SLOT_W'(count_q)) begin
								valid_d      = 1'b1;
								res_d.status = STAT_REJECTED;
							end else begin
								idx_d   = count_q;
								slot_d  = CW'(req.slot);
								state_d = ST_STEP;
							end
						end
						FUNC_DELETE: begin
							if (req.slot >= SLOT_W'(count_q)) begin
								valid_d      = 1'b1;
								res_d.status = STAT_REJECTED;
							end else begin
								idx_d   = CW'(req.slot);
								state_d = ST_STEP;
							end
						end
						FUNC_TRAVERSE: begin
							if (count_q == '0) begin
								valid_d      = 1'b1;
								res_d.status = STAT_EMPTY;
							end else begin
								idx_d   = '0;
								state_d = ST_STEP;
							end
						end
						default: begin
							idx_d   = '0;
							state_d = ST_STEP;
						end
					endcase
				end
			end

			ST_STEP: begin
				res_d      = '0;
				res_d.last = 1'b1;
				unique case (op_q)
					FUNC_INSERT: begin
						if (cmp_lt) begin
							ram_re   = 1'b1;
							ram_ridx = idx_dec;
							state_d  = ST_USE;
						end else begin
							ram_we       = 1'b1;
							ram_widx     = slot_q;
							ram_wdata    = val_q;
							count_d      = count_q + CW'(1);
							valid_d      = 1'b1;
							res_d.status = STAT_INSERTED;
							state_d      = ST_IDLE;
						end
					end
					FUNC_DELETE: begin
						if (cmp_lt) begin
							ram_re   = 1'b1;
							ram_ridx = idx_inc;
							state_d  = ST_USE;
						end else begin
							count_d      = count_q - CW'(1);
							valid_d      = 1'b1;
							res_d.status = STAT_DELETED;
							state_d      = ST_IDLE;
						end
					end
					FUNC_TRAVERSE: begin
						ram_re  = 1'b1;
						state_d = ST_USE;
					end
					default: begin
						if (cmp_lt) begin
							ram_re  = 1'b1;
							state_d = ST_USE;
						end else begin
							valid_d      = 1'b1;
							res_d.status = STAT_NOTFOUND;
							state_d      = ST_IDLE;
						end
					end
				endcase
			end

			ST_USE: begin
				state_d = ST_STEP;
				unique case (op_q)
					FUNC_INSERT: begin
						ram_we = 1'b1;
						idx_d  = idx_dec;
					end
					FUNC_DELETE: begin
						ram_we = 1'b1;
						idx_d  = idx_inc;
					end
					FUNC_TRAVERSE: begin
						valid_d         = 1'b1;
						res_d.status    = STAT_LISTED;
						res_d.out_value = ram_rdata;
						res_d.out_index = INDEX_W'(idx_q);
						res_d.last      = !cmp_lt;
						idx_d           = idx_inc;
						if (!cmp_lt) begin
							state_d = ST_IDLE;
						end
					end
					default: begin
						if (ram_rdata == val_q) begin
							valid_d         = 1'b1;
							res_d           = '0;
							res_d.status    = STAT_FOUND;
							res_d.out_index = INDEX_W'(idx_q);
							res_d.last      = 1'b1;
							state_d         = ST_IDLE;
						end else begin
							idx_d = idx_inc;
						end
					end
				endcase
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		val_q  <= val_d;
		slot_q <= slot_d;
		idx_q  <= idx_d;
		res_q  <= res_d;
	end

	assign busy  = state_q != ST_IDLE;
	assign valid = valid_q;
	assign res   = res_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count exceeds depth");

	a_req_answered: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || valid)
		else $error("accepted request neither started nor answered");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !res.last |-> busy)
		else $error("non-final result with sequencer idle");

	a_ram_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_widx != ram_ridx)
		else $error("RAM read and write hit the same entry");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the ordered array insert/delete/search block.
`timescale 1ns / 1ps
module testbench;
	import oaids_pkg::*;

	localparam int DEPTH      = 64;
	localparam int ITEMS      = 380;
	// Worst case is an insert at the front of a nearly full list plus the idle
	// gap, or a full traverse with 64 strobes. This is several times that.
	localparam int CYCLE_CAP  = 500000;
	localparam int DRAIN      = 20;   // quiet cycles after the last result
	localparam int PRINT_CAP  = 200;  // stop reporting after this many errors

	typedef enum {GROW, SHRINK, MIXED} mix_t;

	// Shadow copy of the list. One transfer in makes one or more
	// expectations; every strobe out is matched against the oldest.
	class list_scoreboard;
		logic signed [VALUE_W-1:0] entries [DEPTH];
		int unsigned               fill_level;
		res_t                      pending [$];
		int unsigned               errors;

		function void push(status_t st, logic signed [VALUE_W-1:0] v, int unsigned idx,
				bit fin);
			res_t r;
			r.status    = st;
			r.out_value = v;
			r.out_index = idx[INDEX_W-1:0];
			r.last      = fin;
			pending.push_back(r);
		endfunction

		// Apply one accepted request to the shadow list and queue its results.
		function void note_request(req_t r);
			int unsigned pos;
			int          hit;
			pos = r.slot;
			hit = -1;
			case (r.func)
			FUNC_INSERT: begin
				if (fill_level >= DEPTH || pos > fill_level) begin
					push(STAT_REJECTED, '0, 0, 1'b1);
				end else begin
					for (int i = fill_level; i > pos; i--)
						entries[i] = entries[i-1];
					entries[pos] = r.item_value;
					fill_level++;
					push(STAT_INSERTED, '0, 0, 1'b1);
				end
			end
			FUNC_DELETE: begin
				if (pos >= fill_level) begin
					push(STAT_REJECTED, '0, 0, 1'b1);
				end else begin
					for (int i = pos; i + 1 < fill_level; i++)
						entries[i] = entries[i+1];
					fill_level--;
					push(STAT_DELETED, '0, 0, 1'b1);
				end
			end
			FUNC_TRAVERSE: begin
				if (fill_level == 0)
					push(STAT_EMPTY, '0, 0, 1'b1);
				for (int i = 0; i < fill_level; i++)
					push(STAT_LISTED, entries[i], i, i + 1 == fill_level);
			end
			default: begin
				// lowest matching index wins
				for (int i = fill_level - 1; i >= 0; i--)
					if (entries[i] == r.item_value)
						hit = i;
				if (hit >= 0)
					push(STAT_FOUND, '0, hit, 1'b1);
				else
					push(STAT_NOTFOUND, '0, 0, 1'b1);
			end
			endcase
		endfunction

		function void field_check(string name, longint want, longint got);
			if (want != got) begin
				errors++;
				if (errors <= PRINT_CAP)
					$display("%0t: %s mismatch: expected %0d, actual %0d",
						$time, name, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= PRINT_CAP)
					$display("%0t: stray result: expected none, actual status %0d value %0d index %0d last %0b",
						$time, got.status, got.out_value, got.out_index, got.last);
				return;
			end
			want = pending.pop_front();
			field_check("status", want.status, got.status);
			field_check("out_value", want.out_value, got.out_value);
			field_check("out_index", want.out_index, got.out_index);
			field_check("last", want.last, got.last);
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  valid;
	res_t  res;

	list_scoreboard sb = new;
	bit             idle_on;      // cleared for back-to-back stretches
	int unsigned    n_sent;
	int unsigned    cycles;

	ordered_array_insert_delete_search #(.DEPTH(DEPTH)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.valid (valid),
		.res   (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a missing strobe ends up here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Results hold for exactly one cycle; sampling mid-cycle sees each once.
	always @(negedge clk) begin
		if (arst_n && valid)
			sb.check_result(res);
	end

	// One request transfer. start stays high across back-to-back requests;
	// it only drops when an idle gap is drawn. busy is sampled at the falling
	// edge, which shows what the next rising edge will see.
	task automatic issue(input func_t f, input logic signed [VALUE_W-1:0] v,
			input int unsigned s);
		int   gap;
		req_t r;
		r.func       = f;
		r.item_value = v;
		r.slot       = s[SLOT_W-1:0];
		gap = idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(negedge clk); while (busy);
		@(posedge clk);
		sb.note_request(r);
		n_sent++;
	endtask

	// Four rolls in ten reuse a stored value so searches hit and duplicates form.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 4 && sb.fill_level > 0)
			return sb.entries[$urandom_range(0, sb.fill_level - 1)];
		if (roll == 4) begin
			case ($urandom_range(0, 3))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return 32'sd0;
			default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	// Slot picking: mostly legal positions, with a slice of full-range noise.
	function automatic int unsigned pick_slot(input bit for_insert);
		int unsigned top;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 127);
		if (for_insert)
			top = sb.fill_level;
		else
			top = (sb.fill_level > 0) ? sb.fill_level - 1 : 0;
		case ($urandom_range(0, 5))
		0:       return 0;
		1:       return top;
		default: return $urandom_range(0, top);
		endcase
	endfunction

	task automatic random_request(input mix_t mix);
		int unsigned roll;
		int          ins_cut;
		int          del_cut;
		int          srch_cut;
		roll = $urandom_range(0, 99);
		case (mix)
		GROW:    begin ins_cut = 70; del_cut = 78; srch_cut = 90; end
		SHRINK:  begin ins_cut = 10; del_cut = 75; srch_cut = 90; end
		default: begin ins_cut = 35; del_cut = 65; srch_cut = 88; end
		endcase
		if (roll < ins_cut)
			issue(FUNC_INSERT, pick_value(), pick_slot(1'b1));
		else if (roll < del_cut)
			issue(FUNC_DELETE, pick_value(), pick_slot(1'b0));
		else if (roll < srch_cut)
			issue(FUNC_SEARCH, pick_value(), pick_slot(1'b0));
		else
			issue(FUNC_TRAVERSE, pick_value(), pick_slot(1'b0));
	endtask

	initial begin
		mix_t mix;
		int   run_len;

		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		cycles = 0;
		n_sent = 0;
		idle_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-list corners first.
		issue(FUNC_TRAVERSE, 32'sd0, 0);            // empty listing
		issue(FUNC_DELETE, 32'sd0, 0);              // delete on empty list
		issue(FUNC_SEARCH, 32'sd5, 0);              // search on empty list
		issue(FUNC_INSERT, 32'sd9, 1);              // insert past count
		issue(FUNC_INSERT, 32'sh8000_0000, 0);      // most negative value
		issue(FUNC_INSERT, 32'sh7fff_ffff, 1);      // append, largest value
		issue(FUNC_INSERT, 32'sd0, 0);              // push to front
		issue(FUNC_INSERT, -32'sd1, 1);             // middle, shifts tail up
		issue(FUNC_INSERT, 32'sd3, 5);              // past count again
		issue(FUNC_INSERT, -32'sd1, 4);             // duplicate appended
		issue(FUNC_SEARCH, -32'sd1, 0);             // first of two matches
		issue(FUNC_SEARCH, 32'sh8000_0000, 0);
		issue(FUNC_SEARCH, 32'sd1234, 0);           // not found
		issue(FUNC_TRAVERSE, 32'sd0, 0);
		issue(FUNC_DELETE, 32'sd0, 5);              // delete at count
		issue(FUNC_DELETE, 32'sd0, 127);            // largest slot code
		issue(FUNC_INSERT, 32'sd1, 127);
		issue(FUNC_DELETE, 32'sd0, 4);              // tail entry
		issue(FUNC_DELETE, 32'sd0, 0);              // head entry
		issue(FUNC_DELETE, 32'sd0, 1);              // middle entry
		issue(FUNC_TRAVERSE, 32'sd0, 0);

		// Fill to capacity, then hit the full-list corners.
		while (sb.fill_level < DEPTH)
			issue(FUNC_INSERT, pick_value(), $urandom_range(0, sb.fill_level));
		issue(FUNC_TRAVERSE, 32'sd0, 0);
		issue(FUNC_INSERT, pick_value(), 0);
		issue(FUNC_INSERT, pick_value(), DEPTH);
		issue(FUNC_SEARCH, sb.entries[DEPTH-1], 0);
		issue(FUNC_DELETE, 32'sd0, DEPTH - 1);

		// Random phases that drift the list up and down, some back-to-back.
		while (n_sent < ITEMS) begin
			case ($urandom_range(0, 2))
			0:       mix = GROW;
			1:       mix = SHRINK;
			default: mix = MIXED;
			endcase
			idle_on = ($urandom_range(0, 3) != 0);
			run_len = $urandom_range(20, 70);
			repeat (run_len)
				if (n_sent < ITEMS)
					random_request(mix);
		end
		start <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
